// ===== sv/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants, types and helpers for the great-circle distance
// Fixed-point formats, CORDIC arctangent table and Q30 helper functions.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam int CORDIC_ITERATIONS = 24;
   localparam int CORDIC_WIDTH      = 36;
   localparam int SQRT_STEPS        = 32;

   typedef logic signed [CORDIC_WIDTH-1:0] cordic_word_type;
   typedef logic [30:0]                    unit_q30_type;

   localparam logic [30:0] Q_ONE        = 31'h4000_0000;
   localparam logic [61:0] Q_HALF       = 62'h2000_0000;
   localparam logic [31:0] DEG_TO_RAD   = 32'd2012227627;
   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
   localparam logic [CORDIC_WIDTH-1:0] CORDIC_GAIN = 36'd652032874;
   localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
   localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
   localparam logic [23:0] RADIUS_RESET = 24'd6371000;

   localparam logic [29:0] ATAN_TAB [0:31] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
      30'h00000001, 30'h00000000
   };

   // Clamps a CORDIC output to the closed unit interval [0, 1.0].
   function automatic unit_q30_type unit_clamp(input cordic_word_type v);
      unit_q30_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({5'b0, Q_ONE})) begin
         r = Q_ONE;
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

   // Q30 product of two unit values, rounded to nearest.
   function automatic unit_q30_type mul_q30(input unit_q30_type a, input unit_q30_type b);
      logic [61:0] p;
      p = 62'(a) * 62'(b) + Q_HALF;
      return p[60:30];
   endfunction

endpackage

// ===== sv/gcd_cordic.sv =====
// ----------------------------------------------------------------------------
// gcd_cordic: pipelined CORDIC, one iteration per register stage
// Rotation mode steers by the sign of z; vectoring mode drives y to zero.
// ----------------------------------------------------------------------------
module gcd_cordic #(
   parameter int ITERATIONS = gcd_pkg::CORDIC_ITERATIONS,
   parameter bit VECTORING  = 1'b0
) (
   input  logic                     clock,
   input  logic                     advance,
   input  gcd_pkg::cordic_word_type x_in,
   input  gcd_pkg::cordic_word_type y_in,
   input  gcd_pkg::cordic_word_type z_in,
   output gcd_pkg::cordic_word_type x_out,
   output gcd_pkg::cordic_word_type y_out,
   output gcd_pkg::cordic_word_type z_out
);

   gcd_pkg::cordic_word_type x_ff [0:ITERATIONS];
   gcd_pkg::cordic_word_type y_ff [0:ITERATIONS];
   gcd_pkg::cordic_word_type z_ff [0:ITERATIONS];

   assign x_ff[0] = x_in;
   assign y_ff[0] = y_in;
   assign z_ff[0] = z_in;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      gcd_pkg::cordic_word_type dx, dy, da;
      gcd_pkg::cordic_word_type x_in_s, y_in_s, z_in_s;
      logic                     fwd;

      always_comb begin
         dx  = y_ff[i] >>> i;
         dy  = x_ff[i] >>> i;
         da  = $signed({6'b0, gcd_pkg::ATAN_TAB[i]});
         // Vectoring turns clockwise while y is positive.
         fwd = VECTORING ? (y_ff[i] <= 0) : (z_ff[i] >= 0);
         if (fwd) begin
            x_in_s = x_ff[i] - dx;
            y_in_s = y_ff[i] + dy;
            z_in_s = z_ff[i] - da;
         end else begin
            x_in_s = x_ff[i] + dx;
            y_in_s = y_ff[i] - dy;
            z_in_s = z_ff[i] + da;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1] <= x_in_s;
            y_ff[i+1] <= y_in_s;
            z_ff[i+1] <= z_in_s;
         end
      end
   end

   assign x_out = x_ff[ITERATIONS];
   assign y_out = y_ff[ITERATIONS];
   assign z_out = z_ff[ITERATIONS];

endmodule

// ===== sv/gcd_isqrt.sv =====
// ----------------------------------------------------------------------------
// gcd_isqrt: pipelined integer square root, one result digit per stage
// Truncated root of a 61-bit operand through 32 restoring steps.
// ----------------------------------------------------------------------------
module gcd_isqrt (
   input  logic        clock,
   input  logic        advance,
   input  logic [60:0] value_in,
   output logic [31:0] root_out
);

   logic [63:0] rem_ff  [0:gcd_pkg::SQRT_STEPS];
   logic [63:0] root_ff [0:gcd_pkg::SQRT_STEPS];

   assign rem_ff[0]  = 64'(value_in);
   assign root_ff[0] = '0;

   for (genvar i = 0; i < gcd_pkg::SQRT_STEPS; i++) begin : g_step
      localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * i);
      logic [63:0] trial;
      logic [63:0] rem_in, root_in;

      always_comb begin
         trial = root_ff[i] + StepBit;
         if (rem_ff[i] >= trial) begin
            rem_in  = rem_ff[i] - trial;
            root_in = (root_ff[i] >> 1) + StepBit;
         end else begin
            rem_in  = rem_ff[i];
            root_in = root_ff[i] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1]  <= rem_in;
            root_ff[i+1] <= root_in;
         end
      end
   end

   assign root_out = root_ff[gcd_pkg::SQRT_STEPS][31:0];

endmodule

// ===== sv/great_circle_distance.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance: haversine distance between two points, pipelined
// Clamp, convert to radians, CORDIC sine/cosine, combine, square roots,
// CORDIC arctangent, then scale by the sphere radius into centimeters.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/ready    | two latitudes, two longitudes
//   rsp     | out       | rsp_valid/ready    | distance_cm
//   csr     | in        | csr_write_enable   | csr_sphere_radius_m
//
// One request enters per cycle while the output is not stalled; the depth is
// set by the two CORDIC pipelines in series and the 32-step square root.
// Reset clears the valid bits and loads the radius with 6371000 meters.
// All stages move together; a result held at the output stalls the whole
// pipeline, bubbles included, until the held result is taken.
// ----------------------------------------------------------------------------
module great_circle_distance #(
   parameter int CORDIC_ITERATIONS = gcd_pkg::CORDIC_ITERATIONS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [30:0] req_second_latitude,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [31:0] req_second_longitude,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_distance_cm,
   input  logic               csr_write_enable,
   input  logic [23:0]        csr_sphere_radius_m
);

   localparam int Latency = 2 * CORDIC_ITERATIONS + 39;

   logic               advance;
   logic [Latency-1:0] vld_ff;
   logic [30:0]        rad100_ff;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[Latency-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rad100_ff <= 31'(gcd_pkg::RADIUS_RESET) * 31'd100;
      end else begin
         if (advance) begin
            vld_ff <= {vld_ff[Latency-2:0], req_valid};
         end
         if (csr_write_enable) begin
            rad100_ff <= 31'(csr_sphere_radius_m) * 31'd100;
         end
      end
   end

   // Stage 1: clamp and take magnitudes.
   logic signed [30:0] lat1_c, lat2_c;
   logic signed [31:0] lon1_c, lon2_c;
   logic signed [31:0] dlat;
   logic signed [32:0] dlon;
   logic [31:0] hlat_m_in, hlon_m_in, hlat_m_ff, hlon_m_ff;
   logic [29:0] r1_m_in, r2_m_in, r1_m_ff, r2_m_ff;

   always_comb begin
      lat1_c = req_first_latitude;
      if (req_first_latitude > gcd_pkg::LAT_LIMIT) lat1_c = gcd_pkg::LAT_LIMIT;
      if (req_first_latitude < -gcd_pkg::LAT_LIMIT) lat1_c = -gcd_pkg::LAT_LIMIT;
      lat2_c = req_second_latitude;
      if (req_second_latitude > gcd_pkg::LAT_LIMIT) lat2_c = gcd_pkg::LAT_LIMIT;
      if (req_second_latitude < -gcd_pkg::LAT_LIMIT) lat2_c = -gcd_pkg::LAT_LIMIT;
      lon1_c = req_first_longitude;
      if (req_first_longitude > gcd_pkg::LON_LIMIT) lon1_c = gcd_pkg::LON_LIMIT;
      if (req_first_longitude < -gcd_pkg::LON_LIMIT) lon1_c = -gcd_pkg::LON_LIMIT;
      lon2_c = req_second_longitude;
      if (req_second_longitude > gcd_pkg::LON_LIMIT) lon2_c = gcd_pkg::LON_LIMIT;
      if (req_second_longitude < -gcd_pkg::LON_LIMIT) lon2_c = -gcd_pkg::LON_LIMIT;

      dlat = 32'(lat2_c) - 32'(lat1_c);
      dlon = 33'(lon2_c) - 33'(lon1_c);
      hlat_m_in = dlat[31] ? 32'(-dlat) : 32'(dlat);
      hlon_m_in = dlon[32] ? 32'(-dlon) : 32'(dlon);
      r1_m_in   = lat1_c[30] ? 30'(-lat1_c) : 30'(lat1_c);
      r2_m_in   = lat2_c[30] ? 30'(-lat2_c) : 30'(lat2_c);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hlat_m_ff <= hlat_m_in;
         hlon_m_ff <= hlon_m_in;
         r1_m_ff   <= r1_m_in;
         r2_m_ff   <= r2_m_in;
      end
   end

   // Stage 2: degrees*1e7 to Q30 radians; the half angles shift one more bit.
   logic [63:0] p_hlat, p_hlon, p_r1, p_r2;
   logic [31:0] hlat_ff, hlon_ff, r1_ff, r2_ff;

   always_comb begin
      p_hlat = 64'(hlat_m_ff) * 64'(gcd_pkg::DEG_TO_RAD) + (64'd1 << 30);
      p_hlon = 64'(hlon_m_ff) * 64'(gcd_pkg::DEG_TO_RAD) + (64'd1 << 30);
      p_r1   = 64'(r1_m_ff) * 64'(gcd_pkg::DEG_TO_RAD) + (64'd1 << 29);
      p_r2   = 64'(r2_m_ff) * 64'(gcd_pkg::DEG_TO_RAD) + (64'd1 << 29);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hlat_ff <= p_hlat[62:31];
         hlon_ff <= p_hlon[62:31];
         r1_ff   <= p_r1[61:30];
         r2_ff   <= p_r2[61:30];
      end
   end

   // Stage 3: a longitude half angle past a quarter turn folds back; sin^2 is unchanged.
   gcd_pkg::cordic_word_type zl_ff, zo_ff, z1_ff, z2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         zl_ff <= $signed(36'(hlat_ff));
         zo_ff <= (hlon_ff > gcd_pkg::HALF_PI_Q30) ?
                  $signed(36'(gcd_pkg::PI_Q30 - hlon_ff)) : $signed(36'(hlon_ff));
         z1_ff <= $signed(36'(r1_ff));
         z2_ff <= $signed(36'(r2_ff));
      end
   end

   gcd_pkg::cordic_word_type sl_w, so_w, c1_w, c2_w;
   gcd_pkg::cordic_word_type gain_w, zero_w;

   assign gain_w = $signed(gcd_pkg::CORDIC_GAIN);
   assign zero_w = '0;

   gcd_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .VECTORING(1'b0)) u_rot_lat (
      .clock(clock), .advance(advance), .x_in(gain_w), .y_in(zero_w), .z_in(zl_ff),
      .x_out(), .y_out(sl_w), .z_out()
   );
   gcd_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .VECTORING(1'b0)) u_rot_lon (
      .clock(clock), .advance(advance), .x_in(gain_w), .y_in(zero_w), .z_in(zo_ff),
      .x_out(), .y_out(so_w), .z_out()
   );
   gcd_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .VECTORING(1'b0)) u_rot_p1 (
      .clock(clock), .advance(advance), .x_in(gain_w), .y_in(zero_w), .z_in(z1_ff),
      .x_out(c1_w), .y_out(), .z_out()
   );
   gcd_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .VECTORING(1'b0)) u_rot_p2 (
      .clock(clock), .advance(advance), .x_in(gain_w), .y_in(zero_w), .z_in(z2_ff),
      .x_out(c2_w), .y_out(), .z_out()
   );

   // Products of the clamped trig values.
   gcd_pkg::unit_q30_type sl2_ff, so2_ff, cc_ff, a_ff;
   gcd_pkg::unit_q30_type t_w;
   logic [31:0]           a_sum;

   always_ff @(posedge clock) begin
      if (advance) begin
         sl2_ff <= gcd_pkg::mul_q30(gcd_pkg::unit_clamp(sl_w), gcd_pkg::unit_clamp(sl_w));
         so2_ff <= gcd_pkg::mul_q30(gcd_pkg::unit_clamp(so_w), gcd_pkg::unit_clamp(so_w));
         cc_ff  <= gcd_pkg::mul_q30(gcd_pkg::unit_clamp(c1_w), gcd_pkg::unit_clamp(c2_w));
      end
   end

   always_comb begin
      t_w   = gcd_pkg::mul_q30(cc_ff, so2_ff);
      a_sum = 32'(sl2_ff) + 32'(t_w);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= (a_sum > 32'(gcd_pkg::Q_ONE)) ? gcd_pkg::Q_ONE : a_sum[30:0];
      end
   end

   logic [31:0] root_a, root_b;

   gcd_isqrt u_sqrt_a (
      .clock(clock), .advance(advance), .value_in({a_ff, 30'b0}), .root_out(root_a)
   );
   gcd_isqrt u_sqrt_b (
      .clock(clock), .advance(advance),
      .value_in({gcd_pkg::Q_ONE - a_ff, 30'b0}), .root_out(root_b)
   );

   gcd_pkg::cordic_word_type ang_w;

   gcd_cordic #(.ITERATIONS(CORDIC_ITERATIONS), .VECTORING(1'b1)) u_atan (
      .clock(clock), .advance(advance),
      .x_in($signed(36'(root_b))), .y_in($signed(36'(root_a))), .z_in(zero_w),
      .x_out(), .y_out(), .z_out(ang_w)
   );

   // Scale the doubled central angle by radius*100, then round and saturate.
   logic [31:0] c_w;
   logic [62:0] prod_ff;
   logic [63:0] dist_sum;
   logic [31:0] dist_ff;

   assign c_w = ang_w[35] ? 32'd0 : {ang_w[30:0], 1'b0};

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= 63'(rad100_ff) * 63'(c_w);
      end
   end

   assign dist_sum = 64'(prod_ff) + 64'(gcd_pkg::Q_HALF);

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= (dist_sum[63:62] != 2'b00) ? 32'hFFFF_FFFF : dist_sum[61:30];
      end
   end

   assign rsp_distance_cm = dist_ff;

   a_reset_empties : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_accept_enters : assert property (@(posedge clock)
      (!reset && req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_radius_scaled : assert property (@(posedge clock)
      (!reset && csr_write_enable) |=>
         rad100_ff == 31'($past(csr_sphere_radius_m)) * 31'd100)
      else $error("radius register not scaled correctly");

endmodule
